FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ACS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ACS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/acs_pkg.sv
package acs_pkg;

    localparam int MEM_DEPTH = 2048;
    localparam int IO_DEPTH  = 32;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int IO_AW     = $clog2(IO_DEPTH);

    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 11;
    localparam int BYTE_W  = 8;
    localparam int PC_W    = 11;
    localparam int INSTR_W = 16;
    localparam int ACC_W   = 16;
    localparam int OP_W    = 5;
    localparam int OPR_W   = 11;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 72;

    localparam logic [CMD_W-1:0] CMD_WRITE_MEM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXECUTE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_MEM  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ_IO   = 2'd3;

    localparam logic [OP_W-1:0] OP_WM   = 5'h01;
    localparam logic [OP_W-1:0] OP_RM   = 5'h02;
    localparam logic [OP_W-1:0] OP_BR   = 5'h03;
    localparam logic [OP_W-1:0] OP_RIO  = 5'h04;
    localparam logic [OP_W-1:0] OP_WIO  = 5'h05;
    localparam logic [OP_W-1:0] OP_WB   = 5'h06;
    localparam logic [OP_W-1:0] OP_WIB  = 5'h07;
    localparam logic [OP_W-1:0] OP_WACC = 5'h09;
    localparam logic [OP_W-1:0] OP_RACC = 5'h0B;
    localparam logic [OP_W-1:0] OP_SWAP = 5'h0E;
    localparam logic [OP_W-1:0] OP_BRLT = 5'h11;
    localparam logic [OP_W-1:0] OP_BRGT = 5'h12;
    localparam logic [OP_W-1:0] OP_BRNE = 5'h13;
    localparam logic [OP_W-1:0] OP_BRE  = 5'h14;
    localparam logic [OP_W-1:0] OP_SHR  = 5'h15;
    localparam logic [OP_W-1:0] OP_SHL  = 5'h16;
    localparam logic [OP_W-1:0] OP_XOR  = 5'h17;
    localparam logic [OP_W-1:0] OP_NOT  = 5'h18;
    localparam logic [OP_W-1:0] OP_OR   = 5'h19;
    localparam logic [OP_W-1:0] OP_AND  = 5'h1A;
    localparam logic [OP_W-1:0] OP_MUL  = 5'h1B;
    localparam logic [OP_W-1:0] OP_SUB  = 5'h1D;
    localparam logic [OP_W-1:0] OP_ADD  = 5'h1E;
    localparam logic [OP_W-1:0] OP_EOP  = 5'h1F;

    typedef struct packed {
        logic ovf;
        logic sign;
        logic carry;
        logic zero;
    } flags_t;

    typedef struct packed {
        logic             acc_we;
        logic [ACC_W-1:0] acc;
        logic             flag_we;
        flags_t           flags;
        logic             take;
    } alu_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_LOAD,
        ST_FINISH
    } seq_state_t;

    typedef enum logic [1:0] {
        LD_MBR,
        LD_IOBR,
        LD_RD_MEM,
        LD_RD_IO
    } load_kind_t;

    function automatic flags_t flags_of(input logic [16:0] r);
        flags_t f;
        f.zero  = (r == 17'd0);
        f.carry = (r > 17'h0FF);
        f.sign  = r[7];
        f.ovf   = (r > 17'h07F);
        return f;
    endfunction

endpackage

FILE: design/accumulator_cpu_step_unit.sv
// Accumulator processor step unit.
// The slave stream carries commands: write a main-store byte, execute one
// instruction, read a main-store byte or read an I/O byte. Every command beat
// yields exactly one master beat with the full register state after the
// command and, for the two read commands, the byte read.
// Commands enter a one-beat input buffer, so a new beat is taken while the
// previous command is still running. Results leave through an output
// register that holds its beat while m_tready is low.
// A write goes from the input buffer to the finish state; a read and an
// instruction that loads MBR or IOBR from a store pass a load state; an
// execute fetches both instruction bytes through the single main-store port.
// Commands run one at a time; a buffered one starts once the previous result
// is registered. Reset clears the state, processor registers, flags and valid
// bits, not the command and output data; the stores are undefined until
// written. On a stall the result waits in the output stage, one more command
// runs to its finish state and waits there, and a further one is buffered.
module accumulator_cpu_step_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // command[1:0], address[12:2], data[20:13], zero pad[23:21]
    input  logic [acs_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // program_counter[10:0], instruction[26:11], accumulator[42:27],
    // memory_buffer[50:43], io_buffer[58:51], zero_flag[59], carry_flag[60],
    // sign_flag[61], overflow_flag[62], halted[63], read_data[71:64]
    output logic [acs_pkg::OUT_W-1:0]   m_tdata
);

    `include "assert_macros.svh"

    localparam int MAW = acs_pkg::MEM_AW;
    localparam int IAW = acs_pkg::IO_AW;

    acs_pkg::seq_state_t state_reg, state_next;
    acs_pkg::load_kind_t kind_reg, kind_next;

    logic                          cmd_full_reg, cmd_full_next;
    logic [acs_pkg::CMD_W-1:0]     cmd_reg;
    logic [acs_pkg::ADDR_W-1:0]    addr_reg;
    logic [acs_pkg::BYTE_W-1:0]    data_reg;

    logic [MAW-1:0]                pc_reg, pc_next;
    logic [acs_pkg::INSTR_W-1:0]   instr_reg, instr_next;
    logic [acs_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [acs_pkg::BYTE_W-1:0]    mbr_reg, mbr_next;
    logic [acs_pkg::BYTE_W-1:0]    iobr_reg, iobr_next;
    acs_pkg::flags_t               flags_reg, flags_next;
    logic                          halt_reg, halt_next;
    logic [acs_pkg::BYTE_W-1:0]    rd_reg, rd_next;
    logic [acs_pkg::BYTE_W-1:0]    hi_reg, hi_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [acs_pkg::OUT_W-1:0]     out_reg, out_next;

    logic                          mem_we;
    logic [MAW-1:0]                mem_addr;
    logic [acs_pkg::BYTE_W-1:0]    mem_wdata, mem_rdata;
    logic                          io_we;
    logic [IAW-1:0]                io_addr;
    logic [acs_pkg::BYTE_W-1:0]    io_rdata;

    logic [acs_pkg::INSTR_W-1:0]   instr;
    logic [acs_pkg::OP_W-1:0]      op;
    logic [acs_pkg::OPR_W-1:0]     opr;
    acs_pkg::alu_res_t             alu_res;
    logic                          s_accept;

    assign s_tready = !cmd_full_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    assign instr = {hi_reg, mem_rdata};
    assign op    = instr[15:11];
    assign opr   = instr[10:0];

    acs_ram #(.DEPTH(acs_pkg::MEM_DEPTH), .WIDTH(acs_pkg::BYTE_W)) u_main_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    acs_ram #(.DEPTH(acs_pkg::IO_DEPTH), .WIDTH(acs_pkg::BYTE_W)) u_io_ram (
        .aclk  (aclk),
        .we    (io_we),
        .addr  (io_addr),
        .wdata (iobr_reg),
        .rdata (io_rdata)
    );

    acs_alu u_alu (
        .op  (op),
        .a   (acc_reg[7:0]),
        .m   (mbr_reg),
        .acc (acc_reg),
        .res (alu_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= acs_pkg::ST_IDLE;
            kind_reg     <= acs_pkg::LD_MBR;
            cmd_full_reg <= 1'b0;
            pc_reg       <= '0;
            instr_reg    <= '0;
            acc_reg      <= '0;
            mbr_reg      <= '0;
            iobr_reg     <= '0;
            flags_reg    <= '0;
            halt_reg     <= 1'b0;
            rd_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            cmd_full_reg <= cmd_full_next;
            pc_reg       <= pc_next;
            instr_reg    <= instr_next;
            acc_reg      <= acc_next;
            mbr_reg      <= mbr_next;
            iobr_reg     <= iobr_next;
            flags_reg    <= flags_next;
            halt_reg     <= halt_next;
            rd_reg       <= rd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg  <= s_tdata[1:0];
            addr_reg <= s_tdata[12:2];
            data_reg <= s_tdata[20:13];
        end
        hi_reg  <= hi_next;
        out_reg <= out_next;
    end

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        cmd_full_next = cmd_full_reg;
        pc_next       = pc_reg;
        instr_next    = instr_reg;
        acc_next      = acc_reg;
        mbr_next      = mbr_reg;
        iobr_next     = iobr_reg;
        flags_next    = flags_reg;
        halt_next     = halt_reg;
        rd_next       = rd_reg;
        hi_next       = hi_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        mem_we        = 1'b0;
        mem_addr      = pc_reg;
        mem_wdata     = mbr_reg;
        io_we         = 1'b0;
        io_addr       = addr_reg[IAW-1:0];

        if (s_accept) begin
            cmd_full_next = 1'b1;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            acs_pkg::ST_IDLE: begin
                if (cmd_full_reg) begin
                    cmd_full_next = 1'b0;
                    rd_next       = '0;
                    case (cmd_reg)
                        acs_pkg::CMD_WRITE_MEM: begin
                            mem_we     = 1'b1;
                            mem_addr   = addr_reg[MAW-1:0];
                            mem_wdata  = data_reg;
                            state_next = acs_pkg::ST_FINISH;
                        end
                        acs_pkg::CMD_EXECUTE: begin
                            mem_addr   = pc_reg;
                            state_next = halt_reg ? acs_pkg::ST_FINISH : acs_pkg::ST_FETCH;
                        end
                        acs_pkg::CMD_READ_MEM: begin
                            mem_addr   = addr_reg[MAW-1:0];
                            kind_next  = acs_pkg::LD_RD_MEM;
                            state_next = acs_pkg::ST_LOAD;
                        end
                        default: begin
                            io_addr    = addr_reg[IAW-1:0];
                            kind_next  = acs_pkg::LD_RD_IO;
                            state_next = acs_pkg::ST_LOAD;
                        end
                    endcase
                end
            end
            acs_pkg::ST_FETCH: begin
                hi_next    = mem_rdata;
                mem_addr   = pc_reg + MAW'(1);
                state_next = acs_pkg::ST_EXEC;
            end
            acs_pkg::ST_EXEC: begin
                instr_next = instr;
                pc_next    = pc_reg + MAW'(2);
                state_next = acs_pkg::ST_FINISH;
                if (alu_res.acc_we) begin
                    acc_next = alu_res.acc;
                end
                if (alu_res.flag_we) begin
                    flags_next = alu_res.flags;
                end
                if (alu_res.take) begin
                    pc_next = opr[MAW-1:0];
                end
                case (op)
                    acs_pkg::OP_WM: begin
                        mem_we   = 1'b1;
                        mem_addr = opr[MAW-1:0];
                    end
                    acs_pkg::OP_RM: begin
                        mem_addr   = opr[MAW-1:0];
                        kind_next  = acs_pkg::LD_MBR;
                        state_next = acs_pkg::ST_LOAD;
                    end
                    acs_pkg::OP_BR: pc_next = opr[MAW-1:0];
                    acs_pkg::OP_RIO: begin
                        io_addr    = opr[IAW-1:0];
                        kind_next  = acs_pkg::LD_IOBR;
                        state_next = acs_pkg::ST_LOAD;
                    end
                    acs_pkg::OP_WIO: begin
                        io_we   = 1'b1;
                        io_addr = opr[IAW-1:0];
                    end
                    acs_pkg::OP_WB:   mbr_next  = instr[7:0];
                    acs_pkg::OP_WIB:  iobr_next = instr[7:0];
                    acs_pkg::OP_RACC: mbr_next  = acc_reg[7:0];
                    acs_pkg::OP_SWAP: begin
                        mbr_next  = iobr_reg;
                        iobr_next = mbr_reg;
                    end
                    acs_pkg::OP_EOP:  halt_next = 1'b1;
                    default:          halt_next = halt_reg;
                endcase
            end
            acs_pkg::ST_LOAD: begin
                state_next = acs_pkg::ST_FINISH;
                case (kind_reg)
                    acs_pkg::LD_MBR:    mbr_next  = mem_rdata;
                    acs_pkg::LD_IOBR:   iobr_next = io_rdata;
                    acs_pkg::LD_RD_MEM: rd_next   = mem_rdata;
                    default:            rd_next   = io_rdata;
                endcase
            end
            acs_pkg::ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_next = {rd_reg, halt_reg, flags_reg.ovf, flags_reg.sign,
                                flags_reg.carry, flags_reg.zero, iobr_reg, mbr_reg,
                                acc_reg, instr_reg, acs_pkg::PC_W'(pc_reg)};
                    state_next = acs_pkg::ST_IDLE;
                end
            end
            default: state_next = acs_pkg::ST_IDLE;
        endcase
    end

    `ACS_ASSERT(a_halt_sticky, aclk, aresetn, halt_reg |=> halt_reg, "halt flag cleared")
    `ACS_ASSERT(a_instr_only_exec, aclk, aresetn,
        (state_reg != acs_pkg::ST_EXEC) |=> $stable(instr_reg), "instruction changed outside execute")
    `ACS_ASSERT(a_no_fetch_write, aclk, aresetn,
        (state_reg == acs_pkg::ST_FETCH) |-> !mem_we, "main store written during fetch")
    `ACS_ASSERT_ALWAYS(a_reset_idle, aclk,
        !aresetn |=> (state_reg == acs_pkg::ST_IDLE && !m_tvalid_reg), "not idle after reset")

endmodule

FILE: design/acs_ram.sv
module acs_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: design/acs_alu.sv
module acs_alu (
    input  logic [acs_pkg::OP_W-1:0]   op,
    input  logic [acs_pkg::BYTE_W-1:0] a,
    input  logic [acs_pkg::BYTE_W-1:0] m,
    input  logic [acs_pkg::ACC_W-1:0]  acc,
    output acs_pkg::alu_res_t          res
);

    logic [8:0]  sum9;
    logic [8:0]  dif9;
    logic [7:0]  diff;
    logic [15:0] prod;
    logic [7:0]  shl;
    logic [7:0]  shr;

    always_comb begin
        sum9 = {1'b0, a} + {1'b0, m};
        dif9 = {1'b0, a} + {1'b0, 8'(-m)};
        diff = a - m;
        prod = 16'($signed(a) * $signed(m));
        shl  = (m >= 8'd8) ? 8'd0 : 8'(a << m[2:0]);
        shr  = (m >= 8'd8) ? 8'd0 : (a >> m[2:0]);

        res = '0;
        case (op)
            acs_pkg::OP_WACC: begin
                res.acc_we = 1'b1;
                res.acc    = {8'd0, m};
            end
            acs_pkg::OP_RACC: res.flag_we = 1'b1;
            acs_pkg::OP_ADD: begin
                res.acc_we = 1'b1;
                res.acc    = {8'd0, sum9[7:0]};
            end
            acs_pkg::OP_SUB: begin
                res.acc_we = 1'b1;
                res.acc    = {8'd0, dif9[7:0]};
            end
            acs_pkg::OP_MUL: begin
                res.acc_we = 1'b1;
                res.acc    = prod;
            end
            acs_pkg::OP_AND: begin
                res.acc_we = 1'b1;
                res.acc    = {8'd0, a & m};
            end
            acs_pkg::OP_OR: begin
                res.acc_we = 1'b1;
                res.acc    = {8'd0, a | m};
            end
            acs_pkg::OP_NOT: begin
                res.acc_we = 1'b1;
                res.acc    = {8'd0, ~a};
            end
            acs_pkg::OP_XOR: begin
                res.acc_we = 1'b1;
                res.acc    = {8'd0, a ^ m};
            end
            acs_pkg::OP_SHL: begin
                res.acc_we = 1'b1;
                res.acc    = {8'd0, shl};
            end
            acs_pkg::OP_SHR: begin
                res.acc_we = 1'b1;
                res.acc    = {8'd0, shr};
            end
            acs_pkg::OP_BRE, acs_pkg::OP_BRNE, acs_pkg::OP_BRGT, acs_pkg::OP_BRLT: begin
                res.acc_we = 1'b1;
                res.acc    = {8'd0, diff};
            end
            default: res.acc = '0;
        endcase

        case (op)
            acs_pkg::OP_ADD:  res.flags = acs_pkg::flags_of({8'd0, sum9});
            acs_pkg::OP_SUB:  res.flags = acs_pkg::flags_of({8'd0, dif9});
            acs_pkg::OP_RACC: res.flags = acs_pkg::flags_of({1'b0, acc});
            default:          res.flags = acs_pkg::flags_of({1'b0, res.acc});
        endcase
        if (res.acc_we) begin
            res.flag_we = 1'b1;
        end

        case (op)
            acs_pkg::OP_BRE:  res.take = res.flags.zero;
            acs_pkg::OP_BRNE: res.take = !res.flags.zero;
            acs_pkg::OP_BRGT: res.take = !res.flags.sign;
            acs_pkg::OP_BRLT: res.take = res.flags.sign;
            default:          res.take = 1'b0;
        endcase
    end

endmodule
